// ===== sv/wrmv_pkg.sv =====
// Shared types and constants of the weighted running mean and variance table.
// Holds the operation, register and job codes, the controller states and the
// command and status structs that join the controller and the datapath.
package wrmv_pkg;

    // Default sizes of the cell map and of the slot table.
    localparam int K_DEF_NUM_CELLS = 65536;
    localparam int K_DEF_NUM_SLOTS = 4096;

    // The shared multiply/divide unit takes one bit per cycle.
    localparam int K_MD_STEPS = 48;
    localparam int K_CNT_W    = 6;

    // Register reset values and the default weight of 1.0 in Q8.16.
    localparam logic [23:0] K_RST_LOW_ID  = 24'd119995;
    localparam logic [23:0] K_RST_HIGH_ID = 24'd119996;
    localparam logic [23:0] K_RST_LOW_W   = 24'd2612304;
    localparam logic [23:0] K_RST_HIGH_W  = 24'd9052;
    localparam logic [23:0] K_ONE_WEIGHT  = 24'd65536;

    localparam logic [39:0] K_MAX40 = '1;
    localparam logic [47:0] K_MAX48 = '1;

    // Map entry: valid bit and slot. Slot word: weight sum, mean, shift, variance.
    localparam int K_MAP_W  = 13;
    localparam int K_WORD_W = 152;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_LOW_ID  = 2'd0,
        REG_HIGH_ID = 2'd1,
        REG_LOW_W   = 2'd2,
        REG_HIGH_W  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_phase;

    // Jobs of the shared unit during an add, in the order they run.
    typedef enum logic [2:0] {
        JOB_T1,
        JOB_GE,
        JOB_GS,
        JOB_H,
        JOB_GH
    } t_job;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_ZERO,
        RES_SLOT
    } t_res;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_MAPCHK,
        S_SLOTRD,
        S_SETUP,
        S_START,
        S_WAIT,
        S_FINAL,
        S_RDDATA,
        S_RES
    } t_state;

    typedef struct packed {
        logic item_load;
        logic map_we;
        logic rd_from_map;
        logic slot_load;
        logic setup;
        logic md_start;
        t_job job;
        logic md_capture;
        logic finalize;
        logic slot_we;
        logic slot_clr;
        logic res_load;
        t_res res_kind;
        logic clr_step;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic cell_bad;
        logic slot_bad;
        logic item_slot_valid;
        logic map_hit;
        logic w_zero;
        logic md_done;
        logic out_free;
        logic clr_last;
    } t_dp_status;

endpackage

// ===== sv/wrmv_ifs.sv =====
// Valid/ready channel interfaces for input items and result items.
// Standalone; no package needed.
interface wrmv_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [15:0]        cell_index;
    logic [11:0]        slot_index;
    logic               slot_valid;
    logic signed [31:0] energy;
    logic signed [31:0] energy_shift;
    logic [23:0]        dataset_id;

    modport source (
        output valid, operation, cell_index, slot_index, slot_valid,
               energy, energy_shift, dataset_id,
        input  ready
    );
    modport sink (
        input  valid, operation, cell_index, slot_index, slot_valid,
               energy, energy_shift, dataset_id,
        output ready
    );
endinterface

interface wrmv_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic [39:0]        weight_sum;
    logic signed [31:0] mean_energy;
    logic signed [31:0] mean_shift;
    logic [47:0]        energy_variance;

    modport source (
        output valid, status, weight_sum, mean_energy, mean_shift, energy_variance,
        input  ready
    );
    modport sink (
        input  valid, status, weight_sum, mean_energy, mean_shift, energy_variance,
        output ready
    );
endinterface

// ===== sv/wrmv_muldiv.sv =====
// Shared bit-serial unit: computes floor(a*b/den), or a*b alone.
// Uses wrmv_pkg for the step count and phase codes.
module wrmv_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_mul_only,
    input  logic [39:0] i_a,
    input  logic [47:0] i_b,
    input  logic [39:0] i_den,
    output logic        o_done,
    output logic [39:0] o_hi,
    output logic [47:0] o_lo
);
    import wrmv_pkg::*;

    t_md_phase          r_phase;
    logic [K_CNT_W-1:0] r_cnt;
    logic               r_done;
    logic               r_mul_only;
    logic [39:0]        r_a;
    logic [39:0]        r_den;
    logic [39:0]        r_hi;
    logic [47:0]        r_lo;

    logic [40:0] msum;
    logic [40:0] dt;
    logic [40:0] dsub;
    logic        dge;
    logic [39:0] drem;
    logic        last;

    // Shift-add step of the multiply and restoring step of the divide.
    always_comb begin
        msum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : 41'd0);
        dt   = {r_hi, r_lo[47]};
        dge  = dt >= {1'b0, r_den};
        dsub = dt - {1'b0, r_den};
        drem = dge ? dsub[39:0] : dt[39:0];
        last = r_cnt == K_CNT_W'(K_MD_STEPS - 1);
    end

    // Phase and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MD_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                MD_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_phase <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (last) begin
                        r_cnt <= '0;
                        if (r_mul_only) begin
                            r_phase <= MD_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_phase <= MD_DIV;
                        end
                    end
                end
                MD_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (last) begin
                        r_phase <= MD_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_phase <= MD_IDLE;
                end
            endcase
        end
    end

    // Operands and the product/quotient word. After the multiply the word is
    // the product; the divide shifts the quotient into its low half.
    always_ff @(posedge i_clk) begin
        case (r_phase)
            MD_IDLE: begin
                if (i_start) begin
                    r_a        <= i_a;
                    r_den      <= i_den;
                    r_mul_only <= i_mul_only;
                    r_hi       <= '0;
                    r_lo       <= i_b;
                end
            end
            MD_MUL: begin
                r_hi <= msum[40:1];
                r_lo <= {msum[0], r_lo[47:1]};
            end
            MD_DIV: begin
                r_hi <= drem;
                r_lo <= {r_lo[46:0], dge};
            end
            default: begin
                r_hi <= r_hi;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_phase == MD_IDLE)
        else $error("Multiply/divide started while busy.");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == MD_DIV |-> r_hi < r_den)
        else $error("Partial remainder not below the divisor.");

endmodule

// ===== sv/wrmv_datapath.sv =====
// Datapath: cell map memory, slot statistics memory, item and result
// registers, and the update arithmetic around the shared wrmv_muldiv unit.
// Uses wrmv_pkg for command/status structs and constants.
module wrmv_datapath #(
    parameter int NUM_CELLS = wrmv_pkg::K_DEF_NUM_CELLS,
    parameter int NUM_SLOTS = wrmv_pkg::K_DEF_NUM_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wrmv_pkg::t_dp_cmd   i_cmd,
    output wrmv_pkg::t_dp_status o_dp_status,
    input  logic [23:0]         i_low_id,
    input  logic [23:0]         i_high_id,
    input  logic [23:0]         i_low_w,
    input  logic [23:0]         i_high_w,
    input  logic [1:0]          i_operation,
    input  logic [15:0]         i_cell_index,
    input  logic [11:0]         i_slot_index,
    input  logic                i_slot_valid,
    input  logic [31:0]         i_energy,
    input  logic [31:0]         i_energy_shift,
    input  logic [23:0]         i_dataset_id,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic                o_res_status,
    output logic [39:0]         o_weight_sum,
    output logic [31:0]         o_mean_energy,
    output logic [31:0]         o_mean_shift,
    output logic [47:0]         o_energy_variance
);
    import wrmv_pkg::*;

    localparam int CW    = $clog2(NUM_CELLS);
    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int MAXD  = (NUM_CELLS > NUM_SLOTS) ? NUM_CELLS : NUM_SLOTS;
    localparam int CLR_W = $clog2(MAXD);

    // Memories.
    logic [K_MAP_W-1:0]  r_map [NUM_CELLS];
    logic [K_WORD_W-1:0] r_slot_mem [NUM_SLOTS];
    logic [K_MAP_W-1:0]  r_map_rd;
    logic [K_WORD_W-1:0] r_slot_rd;
    logic [SW-1:0]       r_rd_addr;
    logic [CLR_W-1:0]    r_clr_cnt;

    // Captured item.
    logic [1:0]  r_op;
    logic [15:0] r_cell;
    logic [11:0] r_slot;
    logic        r_sval;
    logic [31:0] r_energy;
    logic [31:0] r_eshift;
    logic [23:0] r_ds;

    // Slot statistics being worked on and intermediate terms.
    logic [SW-1:0] r_sidx;
    logic [39:0]   r_wold;
    logic [31:0]   r_mean;
    logic [31:0]   r_shift;
    logic [47:0]   r_var;
    logic [23:0]   r_w;
    logic [39:0]   r_a;
    logic [32:0]   r_ade;
    logic [32:0]   r_ads;
    logic          r_de_neg;
    logic          r_ds_neg;
    logic [47:0]   r_t1;
    logic [32:0]   r_ge;
    logic [32:0]   r_gs;
    logic [32:0]   r_h;
    logic [47:0]   r_t2;

    // Result register.
    logic        r_res_valid;
    logic        r_res_status;
    logic [39:0] r_res_wsum;
    logic [31:0] r_res_mean;
    logic [31:0] r_res_shift;
    logic [47:0] r_res_var;

    logic [CW-1:0]       cell_addr;
    logic [SW-1:0]       rd_addr;
    logic [SW-1:0]       wr_addr;
    logic [K_WORD_W-1:0] wr_data;
    logic [23:0]         w;
    logic [40:0]         sum41;
    logic [39:0]         a_sat;
    logic [32:0]         de_e;
    logic [32:0]         de_s;
    logic [31:0]         n_mean;
    logic [31:0]         n_shift;
    logic [48:0]         nv49;
    logic [47:0]         n_var;
    logic [39:0]         md_a;
    logic [47:0]         md_b;
    logic                md_done;
    logic [39:0]         md_hi;
    logic [47:0]         md_lo;

    // Addresses, weight choice and the update terms.
    always_comb begin
        cell_addr = CW'(r_cell);
        rd_addr   = i_cmd.rd_from_map ? SW'(r_map_rd[11:0]) : SW'(r_slot);
        wr_addr   = i_cmd.slot_clr ? r_rd_addr : r_sidx;
        if (r_ds == i_low_id) begin
            w = i_low_w;
        end else if (r_ds == i_high_id) begin
            w = i_high_w;
        end else begin
            w = K_ONE_WEIGHT;
        end
        sum41   = {1'b0, r_wold} + {17'd0, w};
        a_sat   = sum41[40] ? K_MAX40 : sum41[39:0];
        de_e    = {r_energy[31], r_energy} - {r_mean[31], r_mean};
        de_s    = {r_eshift[31], r_eshift} - {r_shift[31], r_shift};
        n_mean  = r_de_neg ? r_mean - r_ge[31:0] : r_mean + r_ge[31:0];
        n_shift = r_ds_neg ? r_shift - r_gs[31:0] : r_shift + r_gs[31:0];
        nv49    = {1'b0, r_t1} + {1'b0, r_t2};
        n_var   = nv49[48] ? K_MAX48 : nv49[47:0];
        wr_data = i_cmd.slot_clr ? '0 : {r_a, n_mean, n_shift, n_var};
    end

    // Operand selection for the shared unit.
    always_comb begin
        case (i_cmd.job)
            JOB_T1: begin
                md_a = r_wold;
                md_b = r_var;
            end
            JOB_GE: begin
                md_a = 40'(r_w);
                md_b = 48'(r_ade);
            end
            JOB_GS: begin
                md_a = 40'(r_w);
                md_b = 48'(r_ads);
            end
            JOB_H: begin
                md_a = r_wold;
                md_b = 48'(r_ade);
            end
            JOB_GH: begin
                md_a = 40'(r_ge);
                md_b = 48'(r_h);
            end
            default: begin
                md_a = '0;
                md_b = '0;
            end
        endcase
    end

    wrmv_muldiv u_muldiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.md_start),
        .i_mul_only (i_cmd.job == JOB_GH),
        .i_a        (md_a),
        .i_b        (md_b),
        .i_den      (r_a),
        .o_done     (md_done),
        .o_hi       (md_hi),
        .o_lo       (md_lo)
    );

    // Cell map: written by the clearing pass or a load, read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            if (32'(r_clr_cnt) < 32'(NUM_CELLS)) begin
                r_map[CW'(r_clr_cnt)] <= '0;
            end
        end else if (i_cmd.map_we) begin
            r_map[cell_addr] <= {r_sval, r_sval ? r_slot : 12'd0};
        end
        r_map_rd <= r_map[cell_addr];
    end

    // Slot table: written by the clearing pass, an add or a read, read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            if (32'(r_clr_cnt) < 32'(NUM_SLOTS)) begin
                r_slot_mem[SW'(r_clr_cnt)] <= '0;
            end
        end else if (i_cmd.slot_we) begin
            r_slot_mem[wr_addr] <= wr_data;
        end
        r_slot_rd <= r_slot_mem[rd_addr];
        r_rd_addr <= rd_addr;
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // Item capture, slot load, setup, unit results and the final update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_op     <= i_operation;
            r_cell   <= i_cell_index;
            r_slot   <= i_slot_index;
            r_sval   <= i_slot_valid;
            r_energy <= i_energy;
            r_eshift <= i_energy_shift;
            r_ds     <= i_dataset_id;
        end
        if (i_cmd.slot_load) begin
            {r_wold, r_mean, r_shift, r_var} <= r_slot_rd;
            r_sidx <= r_rd_addr;
        end
        if (i_cmd.setup) begin
            r_w      <= w;
            r_a      <= a_sat;
            r_de_neg <= de_e[32];
            r_ds_neg <= de_s[32];
            r_ade    <= de_e[32] ? 33'd0 - de_e : de_e;
            r_ads    <= de_s[32] ? 33'd0 - de_s : de_s;
        end
        if (i_cmd.md_capture) begin
            case (i_cmd.job)
                JOB_T1: r_t1 <= md_lo;
                JOB_GE: r_ge <= md_lo[32:0];
                JOB_GS: r_gs <= md_lo[32:0];
                JOB_H:  r_h  <= md_lo[32:0];
                JOB_GH: r_t2 <= (md_hi[39:16] != 24'd0) ? K_MAX48
                                                        : {md_hi[15:0], md_lo[47:16]};
                default: r_t1 <= r_t1;
            endcase
        end
        if (i_cmd.finalize) begin
            r_wold  <= r_a;
            r_mean  <= n_mean;
            r_shift <= n_shift;
            r_var   <= n_var;
        end
    end

    // Result register: holds a result until the transfer on the output side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_kind)
                RES_SLOT: begin
                    r_res_status <= 1'b0;
                    r_res_wsum   <= r_wold;
                    r_res_mean   <= r_mean;
                    r_res_shift  <= r_shift;
                    r_res_var    <= r_var;
                end
                RES_ZERO: begin
                    r_res_status <= 1'b0;
                    r_res_wsum   <= '0;
                    r_res_mean   <= '0;
                    r_res_shift  <= '0;
                    r_res_var    <= '0;
                end
                default: begin
                    r_res_status <= 1'b1;
                    r_res_wsum   <= '0;
                    r_res_mean   <= '0;
                    r_res_shift  <= '0;
                    r_res_var    <= '0;
                end
            endcase
        end
    end

    // Status toward the controller.
    always_comb begin
        o_dp_status.op              = t_op'(r_op);
        o_dp_status.cell_bad        = 32'(r_cell) >= 32'(NUM_CELLS);
        o_dp_status.slot_bad        = 32'(r_slot) >= 32'(NUM_SLOTS);
        o_dp_status.item_slot_valid = r_sval;
        o_dp_status.map_hit         = r_map_rd[K_MAP_W-1];
        o_dp_status.w_zero          = w == 24'd0;
        o_dp_status.md_done         = md_done;
        o_dp_status.out_free        = !r_res_valid || i_res_ready;
        o_dp_status.clr_last        = r_clr_cnt == CLR_W'(MAXD - 1);
    end

    assign o_res_valid       = r_res_valid;
    assign o_res_status      = r_res_status;
    assign o_weight_sum      = r_res_wsum;
    assign o_mean_energy     = r_res_mean;
    assign o_mean_shift      = r_res_shift;
    assign o_energy_variance = r_res_var;

endmodule

// ===== sv/wrmv_ctrl.sv =====
// Controller state machine: sequences clearing, loads, reads and the add jobs
// on the shared unit. Uses wrmv_pkg for states, codes and command/status structs.
module wrmv_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wrmv_pkg::t_dp_status i_status,
    output wrmv_pkg::t_dp_cmd    o_cmd
);
    import wrmv_pkg::*;

    t_state r_state, n_state;
    t_res   r_kind, n_kind;
    t_job   r_job, n_job;

    // State, result kind and current job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_kind  <= RES_FAIL;
            r_job   <= JOB_T1;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_job   <= n_job;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_job      = r_job;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.job  = r_job;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_status.op)
                    OP_LOAD: begin
                        if (i_status.cell_bad ||
                            (i_status.item_slot_valid && i_status.slot_bad)) begin
                            n_kind = RES_FAIL;
                        end else begin
                            o_cmd.map_we = 1'b1;
                            n_kind = RES_ZERO;
                        end
                        n_state = S_RES;
                    end
                    OP_ADD: begin
                        n_state = S_MAPCHK;
                    end
                    OP_READ: begin
                        if (i_status.slot_bad) begin
                            n_kind  = RES_FAIL;
                            n_state = S_RES;
                        end else begin
                            n_state = S_RDDATA;
                        end
                    end
                    default: begin
                        n_kind  = RES_FAIL;
                        n_state = S_RES;
                    end
                endcase
            end
            S_MAPCHK: begin
                if (i_status.cell_bad || !i_status.map_hit) begin
                    n_kind  = RES_FAIL;
                    n_state = S_RES;
                end else begin
                    o_cmd.rd_from_map = 1'b1;
                    n_state = S_SLOTRD;
                end
            end
            S_SLOTRD: begin
                o_cmd.slot_load = 1'b1;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_status.w_zero) begin
                    n_kind  = RES_SLOT;
                    n_state = S_RES;
                end else begin
                    n_job   = JOB_T1;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.md_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.md_done) begin
                    o_cmd.md_capture = 1'b1;
                    n_state = S_START;
                    case (r_job)
                        JOB_T1: n_job = JOB_GE;
                        JOB_GE: n_job = JOB_GS;
                        JOB_GS: n_job = JOB_H;
                        JOB_H:  n_job = JOB_GH;
                        default: n_state = S_FINAL;
                    endcase
                end
            end
            S_FINAL: begin
                o_cmd.finalize = 1'b1;
                o_cmd.slot_we  = 1'b1;
                n_kind  = RES_SLOT;
                n_state = S_RES;
            end
            S_RDDATA: begin
                o_cmd.slot_load = 1'b1;
                o_cmd.slot_we   = 1'b1;
                o_cmd.slot_clr  = 1'b1;
                n_kind  = RES_SLOT;
                n_state = S_RES;
            end
            S_RES: begin
                if (i_status.out_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = r_kind;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_res_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> i_status.out_free)
        else $error("Result loaded over one not yet transferred.");

    a_wait_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.md_start |=> r_state == S_WAIT && !i_status.md_done)
        else $error("Shared unit finished right after its start.");

endmodule

// ===== sv/weighted_running_mean_variance_table_top.sv =====
// Weighted running mean/variance table. After reset the block runs a clearing
// pass over the cell map and slot table, max(NUM_CELLS, NUM_SLOTS) entries
// (65536 at the defaults), and accepts no item until it ends; configuration
// writes are taken throughout. It then works on one item at a time. An add
// makes five passes through one bit-serial multiply/divide unit (48 multiply
// steps and 48 divide steps each, the last multiply only). A finished result
// waits in an output register while the next item is taken.
//
// Depends on wrmv_pkg, wrmv_ifs, wrmv_muldiv, wrmv_datapath and wrmv_ctrl.
module weighted_running_mean_variance_table_top #(
    parameter int NUM_CELLS = wrmv_pkg::K_DEF_NUM_CELLS,
    parameter int NUM_SLOTS = wrmv_pkg::K_DEF_NUM_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wrmv_in_if.sink     i_in,
    wrmv_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wrmv_pkg::*;

    logic [23:0] r_low_id;
    logic [23:0] r_high_id;
    logic [23:0] r_low_w;
    logic [23:0] r_high_w;
    t_reg        reg_sel;
    t_dp_cmd     cmd;
    t_dp_status  dp_status;
    logic        in_ready;

    assign reg_sel = t_reg'(paddr[3:2]);
    assign pready  = 1'b1;

    // Configuration registers, written on the access cycle of a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_id  <= K_RST_LOW_ID;
            r_high_id <= K_RST_HIGH_ID;
            r_low_w   <= K_RST_LOW_W;
            r_high_w  <= K_RST_HIGH_W;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_LOW_ID:  r_low_id  <= pwdata[23:0];
                REG_HIGH_ID: r_high_id <= pwdata[23:0];
                REG_LOW_W:   r_low_w   <= pwdata[23:0];
                REG_HIGH_W:  r_high_w  <= pwdata[23:0];
                default:     r_low_id  <= r_low_id;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_sel)
            REG_LOW_ID:  prdata = {8'd0, r_low_id};
            REG_HIGH_ID: prdata = {8'd0, r_high_id};
            REG_LOW_W:   prdata = {8'd0, r_low_w};
            REG_HIGH_W:  prdata = {8'd0, r_high_w};
            default:     prdata = '0;
        endcase
    end

    assign i_in.ready = in_ready;

    wrmv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    wrmv_datapath #(
        .NUM_CELLS (NUM_CELLS),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_dp_status       (dp_status),
        .i_low_id          (r_low_id),
        .i_high_id         (r_high_id),
        .i_low_w           (r_low_w),
        .i_high_w          (r_high_w),
        .i_operation       (i_in.operation),
        .i_cell_index      (i_in.cell_index),
        .i_slot_index      (i_in.slot_index),
        .i_slot_valid      (i_in.slot_valid),
        .i_energy          (i_in.energy),
        .i_energy_shift    (i_in.energy_shift),
        .i_dataset_id      (i_in.dataset_id),
        .o_res_valid       (o_out.valid),
        .i_res_ready       (o_out.ready),
        .o_res_status      (o_out.status),
        .o_weight_sum      (o_out.weight_sum),
        .o_mean_energy     (o_out.mean_energy),
        .o_mean_shift      (o_out.mean_shift),
        .o_energy_variance (o_out.energy_variance)
    );

endmodule

// ===== bench/wrmv_checker.sv =====
// Scoreboard for the weighted running mean and variance table: watches both channels and
// the register port, predicts every result and compares it field by field.
// Depends on wrmv_pkg and wrmv_ifs.
module wrmv_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wrmv_in_if.sink     i_in,
    wrmv_out_if.sink    i_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import wrmv_pkg::*;

    typedef struct packed {
        logic        status;
        logic [39:0] weight_sum;
        logic [31:0] mean_energy;
        logic [31:0] mean_shift;
        logic [47:0] energy_variance;
    } t_stats;

    logic [23:0] low_id, high_id, low_w, high_w;
    logic        map_valid [K_DEF_NUM_CELLS];
    logic [11:0] map_slot [K_DEF_NUM_CELLS];
    logic [39:0] sum_tab [K_DEF_NUM_SLOTS];
    logic [31:0] mean_tab [K_DEF_NUM_SLOTS];
    logic [31:0] shift_tab [K_DEF_NUM_SLOTS];
    logic [47:0] var_tab [K_DEF_NUM_SLOTS];
    t_stats      expected_stats [$];

    // Moves a Q16.16 mean toward a sample by weight w of total a; returns |d| too.
    function automatic logic [31:0] step_mean(logic [31:0] old, logic [31:0] sample,
                                              logic [23:0] w, logic [39:0] a,
                                              output logic [32:0] mag);
        logic signed [33:0] d;
        logic [63:0]        g;
        d = $signed({{2{sample[31]}}, sample}) - $signed({{2{old[31]}}, old});
        mag = d[33] ? 33'(-d) : 33'(d);
        g = (64'(w) * 64'(mag)) / 64'(a);
        return d[33] ? old - g[31:0] : old + g[31:0];
    endfunction

    // Folds one item into the prediction and returns the expected result.
    function automatic t_stats fold_item(t_op op, logic [15:0] cidx, logic [11:0] slot,
                                         logic valid, logic [31:0] en, logic [31:0] sh,
                                         logic [23:0] ds);
        t_stats       r;
        logic [11:0]  s;
        logic [23:0]  w;
        logic [40:0]  a_full;
        logic [39:0]  a, wold;
        logic [32:0]  mag, mag_s;
        logic [127:0] t1, g, h, gh, t2, nv;
        r = '0;
        r.status = 1'b1;
        case (op)
            OP_LOAD: begin
                map_valid[cidx] = valid;
                map_slot[cidx] = valid ? slot : '0;
                r.status = 1'b0;
            end
            OP_ADD: begin
                if (map_valid[cidx]) begin
                    s = map_slot[cidx];
                    if (ds == low_id) w = low_w;
                    else if (ds == high_id) w = high_w;
                    else w = K_ONE_WEIGHT;
                    if (w != 0) begin
                        wold = sum_tab[s];
                        a_full = 41'(wold) + 41'(w);
                        a = a_full[40] ? K_MAX40 : a_full[39:0];
                        t1 = (128'(wold) * 128'(var_tab[s])) / 128'(a);
                        shift_tab[s] = step_mean(shift_tab[s], sh, w, a, mag_s);
                        mean_tab[s] = step_mean(mean_tab[s], en, w, a, mag);
                        g = (128'(w) * 128'(mag)) / 128'(a);
                        h = (128'(wold) * 128'(mag)) / 128'(a);
                        gh = g * h;
                        t2 = gh >> 16;
                        if (t2 > 128'(K_MAX48)) t2 = 128'(K_MAX48);
                        nv = t1 + t2;
                        var_tab[s] = (nv > 128'(K_MAX48)) ? K_MAX48 : nv[47:0];
                        sum_tab[s] = a;
                    end
                    r = '{1'b0, sum_tab[s], mean_tab[s], shift_tab[s], var_tab[s]};
                end
            end
            OP_READ: begin
                r = '{1'b0, sum_tab[slot], mean_tab[slot], shift_tab[slot], var_tab[slot]};
                sum_tab[slot] = '0;
                mean_tab[slot] = '0;
                shift_tab[slot] = '0;
                var_tab[slot] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Prediction on every input transfer and register write, checks on every result transfer.
    always @(posedge i_clk) begin
        t_stats e, got;
        if (!i_rst_n) begin
            low_id <= K_RST_LOW_ID;
            high_id <= K_RST_HIGH_ID;
            low_w <= K_RST_LOW_W;
            high_w <= K_RST_HIGH_W;
            for (int c = 0; c < K_DEF_NUM_CELLS; c++) map_valid[c] = 1'b0;
            for (int c = 0; c < K_DEF_NUM_SLOTS; c++) begin
                sum_tab[c] = '0;
                mean_tab[c] = '0;
                shift_tab[c] = '0;
                var_tab[c] = '0;
            end
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg'(paddr[3:2]))
                    REG_LOW_ID:  low_id <= pwdata[23:0];
                    REG_HIGH_ID: high_id <= pwdata[23:0];
                    REG_LOW_W:   low_w <= pwdata[23:0];
                    REG_HIGH_W:  high_w <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                expected_stats = {expected_stats, fold_item(t_op'(i_in.operation),
                    i_in.cell_index, i_in.slot_index, i_in.slot_valid, i_in.energy,
                    i_in.energy_shift, i_in.dataset_id)};
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.status, i_out.weight_sum, i_out.mean_energy, i_out.mean_shift,
                        i_out.energy_variance};
                if (expected_stats.size() == 0) begin
                    $error("result transfer with no expected result");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_stats.pop_front();
                    if (got != e) o_fail_count <= o_fail_count + 1;
                    if (got.status != e.status)
                        $error("status: expected %0d, got %0d", e.status, got.status);
                    if (got.weight_sum != e.weight_sum)
                        $error("weight_sum: expected %0h, got %0h", e.weight_sum,
                               got.weight_sum);
                    if (got.mean_energy != e.mean_energy)
                        $error("mean_energy: expected %0h, got %0h", e.mean_energy,
                               got.mean_energy);
                    if (got.mean_shift != e.mean_shift)
                        $error("mean_shift: expected %0h, got %0h", e.mean_shift,
                               got.mean_shift);
                    if (got.energy_variance != e.energy_variance)
                        $error("energy_variance: expected %0h, got %0h",
                               e.energy_variance, got.energy_variance);
                end
            end
        end
        // Number of results still owed by the block.
        o_pending = expected_stats.size();
    end
endmodule

// ===== bench/weighted_running_mean_variance_table_top_tb.sv =====
// Testbench top for the weighted running mean and variance table: drives items and
// register writes, stalls the result side at random and gives the verdict.
// Depends on wrmv_pkg, wrmv_ifs, wrmv_checker and the block.
module weighted_running_mean_variance_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wrmv_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          idle_cycles = 0;
    logic [15:0] cells [8];

    wrmv_in_if  in_ch ();
    wrmv_out_if out_ch ();

    weighted_running_mean_variance_table_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wrmv_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .i_out(out_ch.sink),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side: a fresh random stall before every result transfer.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            repeat (gap) @(negedge i_clk);
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
            out_ch.ready <= 1'b0;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(t_reg index, logic [23:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= {8'h00, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // One input transfer after a random gap; the gap may be zero to keep valid high.
    task automatic send_item(t_op op, logic [15:0] cell_idx, logic [11:0] slot, logic sv,
                             logic [31:0] en, logic [31:0] sh, logic [23:0] ds, bit hurry);
        int gap;
        gap = hurry ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.cell_index <= cell_idx;
        in_ch.slot_index <= slot;
        in_ch.slot_valid <= sv;
        in_ch.energy <= en;
        in_ch.energy_shift <= sh;
        in_ch.dataset_id <= ds;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    function automatic logic [23:0] pick_ds();
        case ($urandom_range(0, 3))
            0: return u_checker.low_id;
            1: return u_checker.high_id;
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    initial begin
        t_op         op;
        logic [23:0] lid, hid;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_LOAD;
        in_ch.cell_index = '0;
        in_ch.slot_index = '0;
        in_ch.slot_valid = 1'b0;
        in_ch.energy = '0;
        in_ch.energy_shift = '0;
        in_ch.dataset_id = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: map extremes, default weights, zero weight, unmapped and unknown ops.
        send_item(OP_LOAD, 16'hFFFF, 12'hFFF, 1'b1, 0, 0, 0, 0);
        send_item(OP_LOAD, 16'h0000, 12'h000, 1'b1, 0, 0, 0, 0);
        send_item(OP_ADD, 16'hFFFF, 0, 0, 32'h7FFFFFFF, 32'h80000000, K_RST_LOW_ID, 0);
        send_item(OP_ADD, 16'hFFFF, 0, 0, 32'h80000000, 32'h7FFFFFFF, K_RST_HIGH_ID, 1);
        send_item(OP_ADD, 16'hFFFF, 0, 0, 32'h00010000, 32'hFFFF0000, 24'hFFFFFF, 0);
        send_item(OP_ADD, 16'h0000, 0, 0, 32'hFFFFFFFF, 32'h00000001, 24'h000000, 0);
        send_item(OP_ADD, 16'h1234, 0, 0, 32'h12345678, 32'h0, 24'h0, 0);
        send_item(OP_NONE, 16'h5555, 12'hAAA, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 0);
        send_item(OP_READ, 16'h0, 12'hFFF, 0, 0, 0, 0, 1);
        send_item(OP_READ, 16'h0, 12'hFFF, 0, 0, 0, 0, 0);
        send_item(OP_LOAD, 16'h0000, 12'h000, 1'b0, 0, 0, 0, 0);
        send_item(OP_ADD, 16'h0000, 0, 0, 32'h100, 0, 0, 0);
        drain();
        write_reg(REG_LOW_W, 24'h000000);
        write_reg(REG_HIGH_W, 24'hFFFFFF);
        write_reg(REG_LOW_ID, 24'h000000);
        write_reg(REG_HIGH_ID, 24'hFFFFFF);
        send_item(OP_ADD, 16'hFFFF, 0, 0, 32'h0, 32'h0, 24'h000000, 0);
        send_item(OP_ADD, 16'hFFFF, 0, 0, 32'h7FFFFFFF, 32'h0, 24'hFFFFFF, 0);
        send_item(OP_ADD, 16'hFFFF, 0, 0, 32'h80000000, 32'h1, 24'hFFFFFF, 0);
        send_item(OP_READ, 16'h0, 12'hFFF, 0, 0, 0, 0, 0);

        // Random phases with different register settings; a few cells keep slots busy.
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            lid = 24'($urandom_range(0, 24'hFFFFFF));
            hid = (phase == 3) ? lid : 24'($urandom_range(0, 24'hFFFFFF));
            write_reg(REG_LOW_ID, lid);
            write_reg(REG_HIGH_ID, hid);
            write_reg(REG_LOW_W, (phase == 0) ? 24'hFFFFFF
                                              : 24'($urandom_range(0, 24'hFFFFFF)));
            write_reg(REG_HIGH_W, (phase == 1) ? 24'h0
                                               : 24'($urandom_range(0, 24'hFFFFFF)));
            for (int c = 0; c < 8; c++) begin
                cells[c] = 16'($urandom_range(0, 16'hFFFF));
                send_item(OP_LOAD, cells[c], 12'($urandom_range(0, 7)), 1'b1, 0, 0, 0,
                          1'($urandom_range(0, 1)));
            end
            for (int k = 0; k < 190; k++) begin
                case ($urandom_range(0, 19))
                    0, 1:    op = OP_LOAD;
                    2, 3:    op = OP_READ;
                    4:       op = OP_NONE;
                    default: op = OP_ADD;
                endcase
                send_item(op, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                          cells[$urandom_range(0, 7)],
                          ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 7)),
                          ($urandom_range(0, 5) != 0), $urandom, $urandom, pick_ds(),
                          ($urandom_range(0, 3) == 0));
            end
        end
        drain();

        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
